@@ rtl/bounded_double_ended_queue_top_defines.svh @@
// assertion macros used by the deque control block
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define BDEQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define BDEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bdeq_pkg.sv @@
`timescale 1ns / 1ps

package bdeq_pkg;

    // sizing defaults
    localparam int DEFAULT_MAX_DEPTH = 1024;
    localparam int WORD_W            = 32;
    localparam int CAP_W             = 11;
    localparam int ACTION_W          = 3;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 32;

    // register map and reset values
    localparam logic [CFG_ADDR_W-3:0] REG_CAPACITY = '0;
    localparam logic [CAP_W-1:0]      CAP_RESET    = 11'd1024;

    // front and rear value reported for an empty queue
    localparam logic signed [WORD_W-1:0] WORD_NONE = 32'hFFFF_FFFF;

    // action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_QUERY      = 3'd4
    } t_action;

    // input word
    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic signed [WORD_W-1:0] value;
    } t_in_word;

    // result word
    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
    } t_out_word;

    // status of the word waiting for its slot reads
    typedef struct packed {
        logic valid;
        logic ok;
        logic empty;
        logic full;
    } t_stage_status;

endpackage

@@ rtl/bdeq_cfg.sv @@
`timescale 1ns / 1ps

module bdeq_cfg
    import bdeq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CAP_W-1:0]      o_capacity
);

    logic [CAP_W-1:0]        r_capacity;
    logic [CAP_W-1:0]        n_capacity;
    logic                    wr_capacity;
    logic [CFG_ADDR_W-3:0]   reg_index;

    assign reg_index   = paddr[CFG_ADDR_W-1:2];
    assign wr_capacity = psel && penable && pwrite && pready && (reg_index == REG_CAPACITY);

    // capacity register
    always_comb begin
        n_capacity = r_capacity;
        if (wr_capacity) begin
            n_capacity = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else begin
            r_capacity <= n_capacity;
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (reg_index == REG_CAPACITY) begin
            prdata = CFG_DATA_W'(r_capacity);
        end
    end

    assign pready     = 1'b1;
    assign o_capacity = r_capacity;

endmodule

@@ rtl/bdeq_mem.sv @@
`timescale 1ns / 1ps

module bdeq_mem
    import bdeq_pkg::*;
#(
    parameter int DEPTH  = DEFAULT_MAX_DEPTH,
    parameter int ADDR_W = $clog2(DEFAULT_MAX_DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [ADDR_W-1:0]        i_wr_addr,
    input  logic signed [WORD_W-1:0] i_wr_data,
    input  logic                     i_rd_en,
    input  logic [ADDR_W-1:0]        i_rd_addr_a,
    input  logic [ADDR_W-1:0]        i_rd_addr_b,
    output logic signed [WORD_W-1:0] o_rd_data_a,
    output logic signed [WORD_W-1:0] o_rd_data_b
);

    logic signed [WORD_W-1:0] r_mem [DEPTH];
    logic signed [WORD_W-1:0] r_rd_data_a;
    logic signed [WORD_W-1:0] r_rd_data_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // two registered read ports, old data on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data_a <= r_mem[i_rd_addr_a];
            r_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

@@ rtl/bdeq_ctrl.sv @@
`timescale 1ns / 1ps

`include "bounded_double_ended_queue_top_defines.svh"

module bdeq_ctrl
    import bdeq_pkg::*;
#(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH,
    parameter int IDX_W     = $clog2(DEFAULT_MAX_DEPTH),
    parameter int CNT_W     = $clog2(DEFAULT_MAX_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  t_in_word                 i_in_word,
    output logic                     o_in_ready,
    input  logic [CAP_W-1:0]         i_capacity,
    input  logic                     i_adv,
    output t_stage_status            o_status,
    output logic [IDX_W-1:0]         o_front_idx,
    output logic [IDX_W-1:0]         o_rear_idx,
    output logic                     o_wr_en,
    output logic [IDX_W-1:0]         o_wr_addr,
    output logic signed [WORD_W-1:0] o_wr_data
);

    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [IDX_W-1:0] r_front;
    logic [IDX_W-1:0] n_front;
    logic [IDX_W-1:0] r_rear;
    logic [IDX_W-1:0] n_rear;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_stage_status    r_status;
    t_stage_status    n_status;

    logic             accept;
    logic [CMP_W-1:0] cap_eff;
    logic             full_now;
    logic             ok;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] front_prev;
    logic [IDX_W-1:0] front_next;
    logic [IDX_W-1:0] rear_prev;
    logic [IDX_W-1:0] rear_next;

    assign o_in_ready = !r_status.valid || i_adv;
    assign accept     = i_in_valid && o_in_ready;

    // capacity in effect saturates at the ring depth
    always_comb begin
        cap_eff = CMP_W'(i_capacity);
        if (CMP_W'(i_capacity) > CMP_W'(MAX_DEPTH)) begin
            cap_eff = CMP_W'(MAX_DEPTH);
        end
    end

    assign full_now = CMP_W'(r_count) >= cap_eff;

    // ring index neighbors
    assign front_prev = (r_front == '0) ? IDX_W'(MAX_DEPTH - 1) : r_front - 1'b1;
    assign front_next = (r_front == IDX_W'(MAX_DEPTH - 1)) ? '0 : r_front + 1'b1;
    assign rear_prev  = (r_rear == '0) ? IDX_W'(MAX_DEPTH - 1) : r_rear - 1'b1;
    assign rear_next  = (r_rear == IDX_W'(MAX_DEPTH - 1)) ? '0 : r_rear + 1'b1;

    // action decode and index update
    always_comb begin
        n_front = r_front;
        n_rear  = r_rear;
        n_count = r_count;
        ok      = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_front;
        case (i_word_action(i_in_word))
            ACT_PUSH_FRONT: begin
                ok = !full_now;
                if (ok) begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                    if (r_count == '0) begin
                        n_rear = r_front;
                    end else begin
                        n_front = front_prev;
                        wr_addr = front_prev;
                    end
                end
            end
            ACT_PUSH_BACK: begin
                ok = !full_now;
                if (ok) begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                    if (r_count == '0) begin
                        n_rear = r_front;
                    end else begin
                        n_rear  = rear_next;
                        wr_addr = rear_next;
                    end
                end
            end
            ACT_POP_FRONT: begin
                ok = r_count != '0;
                if (ok) begin
                    n_count = r_count - 1'b1;
                    if (r_count > CNT_W'(1)) begin
                        n_front = front_next;
                    end
                end
            end
            ACT_POP_BACK: begin
                ok = r_count != '0;
                if (ok) begin
                    n_count = r_count - 1'b1;
                    if (r_count > CNT_W'(1)) begin
                        n_rear = rear_prev;
                    end
                end
            end
            ACT_QUERY: begin
                ok = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // status of the word waiting for its slot reads
    always_comb begin
        n_status = r_status;
        if (accept) begin
            n_status.valid = 1'b1;
            n_status.ok    = ok;
            n_status.empty = n_count == '0;
            n_status.full  = CMP_W'(n_count) >= cap_eff;
        end else if (i_adv) begin
            n_status.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_rear   <= '0;
            r_count  <= '0;
            r_status <= '0;
        end else begin
            r_status <= n_status;
            if (accept) begin
                r_front <= n_front;
                r_rear  <= n_rear;
                r_count <= n_count;
            end
        end
    end

    assign o_status    = r_status;
    assign o_front_idx = r_front;
    assign o_rear_idx  = r_rear;
    assign o_wr_en     = accept && wr_en;
    assign o_wr_addr   = wr_addr;
    assign o_wr_data   = i_in_word.value;

    // action field of an input word as an action code
    function automatic t_action i_word_action(input t_in_word word);
        return t_action'(word.action);
    endfunction

    // checks
    `BDEQ_ASSERT_NEXT(a_push_counts, i_clk, i_rst_n,
        o_wr_en, r_count == $past(r_count) + 1'b1,
        "successful push did not raise the entry count")
    `BDEQ_ASSERT_SAME(a_single_entry, i_clk, i_rst_n,
        r_count == CNT_W'(1), r_front == r_rear,
        "single entry but front and rear slots differ")
    `BDEQ_ASSERT_SAME(a_write_on_push, i_clk, i_rst_n,
        o_wr_en, accept && (i_in_word.action == ACT_PUSH_FRONT ||
        i_in_word.action == ACT_PUSH_BACK),
        "slot written without an accepted push")

endmodule

@@ rtl/bounded_double_ended_queue_top.sv @@
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit words kept in a ring buffer.
// Input channel (i_in_valid / o_in_ready / i_in_word) carries one action:
// push front, push back, pop front, pop back or query. Output channel
// (o_out_valid / i_out_ready / o_out_word) returns one result word per
// action: success, front and rear words after the action (-1 when empty),
// and the empty and full flags.
// The APB port holds the capacity register at address 0; write it only
// while no action is in flight.
// Throughput: one action per cycle while the receiver takes results. On
// acceptance of the input word the indices, the count and the pushed slot
// are updated; the front and rear slots are then read through the two read
// ports of the slot memory into the output register.
// Reset clears the indices and the count (queue empty) and sets the
// capacity to 1024; the slot memory is not cleared and needs no sweep.
// When the receiver stalls, the result holds in the output register and
// the input channel takes at most one more word before o_in_ready drops.

module bounded_double_ended_queue_top
    import bdeq_pkg::*;
#(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(MAX_DEPTH);
    localparam int CNT_W = $clog2(MAX_DEPTH + 1);

    logic [CAP_W-1:0]         capacity;
    t_stage_status            status;
    logic                     adv;
    logic [IDX_W-1:0]         front_idx;
    logic [IDX_W-1:0]         rear_idx;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [WORD_W-1:0] wr_data;
    logic signed [WORD_W-1:0] rd_front;
    logic signed [WORD_W-1:0] rd_rear;

    logic r_out_valid;
    logic n_out_valid;
    logic r_out_ok;
    logic r_out_empty;
    logic r_out_full;

    // configuration registers
    bdeq_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    // index and count update
    bdeq_ctrl #(
        .MAX_DEPTH (MAX_DEPTH),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_ready  (o_in_ready),
        .i_capacity  (capacity),
        .i_adv       (adv),
        .o_status    (status),
        .o_front_idx (front_idx),
        .o_rear_idx  (rear_idx),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // slot memory, front and rear read together
    bdeq_mem #(
        .DEPTH  (MAX_DEPTH),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (adv),
        .i_rd_addr_a (front_idx),
        .i_rd_addr_b (rear_idx),
        .o_rd_data_a (rd_front),
        .o_rd_data_b (rd_rear)
    );

    // the pending word moves into the output register when it is free
    assign adv = status.valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_out_valid = r_out_valid;
        if (adv) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result flags, loaded with the slot reads
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_ok    <= status.ok;
            r_out_empty <= status.empty;
            r_out_full  <= status.full;
        end
    end

    // result word
    assign o_out_valid            = r_out_valid;
    assign o_out_word.ok          = r_out_ok;
    assign o_out_word.front_value = r_out_empty ? WORD_NONE : rd_front;
    assign o_out_word.rear_value  = r_out_empty ? WORD_NONE : rd_rear;
    assign o_out_word.is_empty    = r_out_empty;
    assign o_out_word.is_full     = r_out_full;

endmodule

@@ bench/tb_bounded_double_ended_queue_top.sv @@
`timescale 1ns / 1ps

module tb_bounded_double_ended_queue_top;
    import bdeq_pkg::*;

    localparam int DEPTH     = DEFAULT_MAX_DEPTH;
    localparam int SLOT_W    = $clog2(DEPTH);
    localparam int LIMIT     = 300000;
    localparam int LONG_HOLD = 400;
    // action codes the block must reject
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;
    // capacity settings
    localparam logic [CAP_W-1:0] CAP_NONE      = 11'd0;
    localparam logic [CAP_W-1:0] CAP_ONE       = 11'd1;
    localparam logic [CAP_W-1:0] CAP_EIGHT     = 11'd8;
    localparam logic [CAP_W-1:0] CAP_TWO       = 11'd2;
    localparam logic [CAP_W-1:0] CAP_FULL_SCALE = 11'd1024;
    localparam logic [CAP_W-1:0] CAP_TOP       = 11'd2047;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_word = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_word;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // words waiting to be offered and results still owed by the block
    t_in_word  action_backlog[$];
    t_out_word deque_status_q[$];

    // shadow copy of the deque
    logic [WORD_W-1:0] ring_words [DEPTH];
    logic [SLOT_W-1:0] head_slot = '0;
    logic [SLOT_W-1:0] tail_slot = '0;
    int                live_count = 0;
    int                cap_setting = CAP_RESET;

    int   error_count = 0;
    int   cycle_count;
    bit   idle_on = 1'b1;
    bit   long_hold_req = 1'b0;
    bit   long_hold_done = 1'b0;
    logic in_took = 1'b0;
    int   send_gap = 0;
    int   hold_left = 0;

    bounded_double_ended_queue_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // apply one action to the shadow deque and return the status it reports
    function automatic t_out_word predict_deque_action(t_in_word w);
        t_out_word r;
        int        cap_eff;
        logic      ok;
        cap_eff = (cap_setting > DEPTH) ? DEPTH : cap_setting;
        ok = 1'b0;
        case (w.action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                ok = live_count < cap_eff;
                if (ok) begin
                    if (live_count == 0) begin
                        tail_slot = head_slot;
                    end else if (w.action == ACT_PUSH_FRONT) begin
                        head_slot = head_slot - 1'b1;
                    end else begin
                        tail_slot = tail_slot + 1'b1;
                    end
                    if (w.action == ACT_PUSH_FRONT) begin
                        ring_words[head_slot] = w.value;
                    end else begin
                        ring_words[tail_slot] = w.value;
                    end
                    live_count++;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
                ok = live_count != 0;
                if (ok) begin
                    if (live_count > 1) begin
                        if (w.action == ACT_POP_FRONT) begin
                            head_slot = head_slot + 1'b1;
                        end else begin
                            tail_slot = tail_slot - 1'b1;
                        end
                    end
                    live_count--;
                end
            end
            ACT_QUERY: begin
                ok = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        r.ok          = ok;
        r.is_empty    = live_count == 0;
        r.is_full     = live_count >= cap_eff;
        r.front_value = r.is_empty ? WORD_NONE : ring_words[head_slot];
        r.rear_value  = r.is_empty ? WORD_NONE : ring_words[tail_slot];
        return r;
    endfunction

    function automatic t_in_word deque_cmd(logic [ACTION_W-1:0] act, logic [WORD_W-1:0] val);
        t_in_word w;
        w.action = act;
        w.value  = val;
        return w;
    endfunction

    // random action, push share in percent
    function automatic t_in_word random_cmd(int push_pct);
        t_in_word w;
        int       pick;
        w.value = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < push_pct) begin
            w.action = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                w.action = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
            end else if (pick < 92) begin
                w.action = ACT_QUERY;
            end else begin
                w.action = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
            end
        end
        return w;
    endfunction

    // wait until every word is taken and every result is back
    // checked at the rising edge, where the sender's outputs are settled
    task automatic settle();
        while (action_backlog.size() != 0 || i_in_valid || deque_status_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_phase(input int n_items, input int push_pct);
        repeat (n_items) action_backlog.push_back(random_cmd(push_pct));
        settle();
    endtask

    // apb write of the capacity register, setup then access
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= {(CFG_DATA_W - CAP_W)'($urandom), cap};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_setting = cap;
    endtask

    // sender: offers the next word once the current one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_took)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (action_backlog.size() > 0) begin
                i_in_word  <= action_backlog.pop_front();
                i_in_valid <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(1, 19);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall bursts plus one long hold-off
    always @(negedge i_clk) begin
        if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 19) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor: check results in order, predict accepted words
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (deque_status_q.size() == 0) begin
                    $error("result word with nothing expected");
                    error_count++;
                end else begin
                    want = deque_status_q.pop_front();
                    if (o_out_word.ok !== want.ok) begin
                        $error("ok: expected %0d, actual %0d", want.ok, o_out_word.ok);
                        error_count++;
                    end
                    if (o_out_word.front_value !== want.front_value) begin
                        $error("front_value: expected %0d, actual %0d",
                               want.front_value, o_out_word.front_value);
                        error_count++;
                    end
                    if (o_out_word.rear_value !== want.rear_value) begin
                        $error("rear_value: expected %0d, actual %0d",
                               want.rear_value, o_out_word.rear_value);
                        error_count++;
                    end
                    if (o_out_word.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, actual %0d",
                               want.is_empty, o_out_word.is_empty);
                        error_count++;
                    end
                    if (o_out_word.is_full !== want.is_full) begin
                        $error("is_full: expected %0d, actual %0d",
                               want.is_full, o_out_word.is_full);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                deque_status_q.push_back(predict_deque_action(i_in_word));
            end
        end
        in_took <= i_in_valid && o_in_ready;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // test sequence
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // directed: empty pops, extreme words, both ends, unknown actions
        action_backlog.push_back(deque_cmd(ACT_QUERY, 32'h0000_0000));
        action_backlog.push_back(deque_cmd(ACT_POP_FRONT, 32'hFFFF_FFFF));
        action_backlog.push_back(deque_cmd(ACT_POP_BACK, 32'h0000_0000));
        action_backlog.push_back(deque_cmd(ACT_PUSH_FRONT, 32'h8000_0000));
        action_backlog.push_back(deque_cmd(ACT_PUSH_BACK, 32'h7FFF_FFFF));
        action_backlog.push_back(deque_cmd(ACT_QUERY, 32'hFFFF_FFFF));
        action_backlog.push_back(deque_cmd(ACT_POP_FRONT, 32'h0000_0000));
        action_backlog.push_back(deque_cmd(ACT_POP_BACK, 32'h0000_0000));
        action_backlog.push_back(deque_cmd(ACT_POP_BACK, 32'h0000_0000));
        action_backlog.push_back(deque_cmd(ACT_PUSH_BACK, 32'h0000_0000));
        action_backlog.push_back(deque_cmd(ACT_PUSH_FRONT, 32'hFFFF_FFFF));
        action_backlog.push_back(deque_cmd(ACT_PUSH_FRONT, 32'hAAAA_AAAA));
        action_backlog.push_back(deque_cmd(ACT_PUSH_BACK, 32'h5555_5555));
        action_backlog.push_back(deque_cmd(ACT_UNUSED_LO, 32'h1234_5678));
        action_backlog.push_back(deque_cmd(ACT_UNUSED_LO + 3'd1, 32'hFFFF_FFFF));
        action_backlog.push_back(deque_cmd(ACT_UNUSED_HI, 32'h8000_0000));
        action_backlog.push_back(deque_cmd(ACT_POP_BACK, 32'h0000_0000));
        action_backlog.push_back(deque_cmd(ACT_POP_FRONT, 32'h0000_0000));
        action_backlog.push_back(deque_cmd(ACT_POP_FRONT, 32'h0000_0000));
        action_backlog.push_back(deque_cmd(ACT_POP_FRONT, 32'h0000_0000));
        action_backlog.push_back(deque_cmd(ACT_QUERY, 32'h0000_0000));
        settle();

        // zero capacity: every push fails, empty and full together
        write_capacity(CAP_NONE);
        run_phase(30, 60);

        // single entry
        write_capacity(CAP_ONE);
        run_phase(60, 50);

        // fill a small queue, then lower the capacity below the count
        write_capacity(CAP_EIGHT);
        run_phase(40, 85);
        write_capacity(CAP_TWO);
        run_phase(80, 40);

        // mid-size random capacity, balanced traffic
        write_capacity(CAP_W'($urandom_range(3, 40)));
        run_phase(150, 55);

        // saturated capacity: receiver holds off while the block stalls its input
        write_capacity(CAP_TOP);
        long_hold_req = 1'b1;
        run_phase(300, 100);
        run_phase(40, 50);

        // exact full-scale capacity, no idling on either side
        write_capacity(CAP_FULL_SCALE);
        idle_on = 1'b0;
        run_phase(80, 45);

        repeat (8) @(negedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
